### hw/rtl/u8sd_pkg.sv
// UTF-8 stream decoder package: byte classes, masks and field widths.
// Used by utf8_stream_decoder_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8sd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CP_W      = 21;
    localparam int PEND_W    = 2;
    localparam int OUT_DATA_W = ((CP_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

    localparam logic [PEND_W-1:0] PEND_IDLE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THR  = 2'd3;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            has_code_point;
        logic            end_of_string;
    } u8sd_result_t;

endpackage

`default_nettype wire

### hw/rtl/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder top level: input register, byte decode, result register.
// Depends on u8sd_pkg.
// Throughput: one byte per cycle while m_tready does not stall the output; set
// by the single decode step between the input register and the result register,
// which also updates the sequence state. Reset (rst_n low, asynchronous) empties
// both registers and returns the decoder to idle with no partial code point.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_unit
    import u8sd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
    input  wire logic                  s_tlast,   // last_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [20:0] code_point, [23:21] zero
    output logic                       m_tuser,   // [0] has_code_point
    output logic                       m_tlast    // end_of_string
);

    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    logic              out_vld_reg;
    u8sd_result_t      out_reg;
    u8sd_result_t      out_next;

    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;
    logic [CP_W-1:0]   part_reg;
    logic [CP_W-1:0]   part_next;

    logic              out_free;
    logic              fire;
    logic              done;
    logic [CP_W-1:0]   cp;
    logic [CP_W-1:0]   shifted;
    logic [PEND_W-1:0] pend_dec;

    assign out_free = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    assign shifted  = {part_reg[CP_W-7:0], in_byte_reg[5:0] & CONT_MASK[5:0]};
    assign pend_dec = pend_reg - PEND_ONE;

    always_comb
    begin
        pend_next = pend_reg;
        part_next = part_reg;
        done      = 1'b0;
        cp        = '0;
        if (pend_reg != PEND_IDLE)
        begin
            pend_next = pend_dec;
            if (pend_dec == PEND_IDLE)
            begin
                done      = 1'b1;
                cp        = shifted;
                part_next = '0;
            end
            else
            begin
                part_next = shifted;
            end
        end
        else
        begin
            case (in_byte_reg) inside
                [8'h00:ASCII_MAX]:
                begin
                    done = 1'b1;
                    cp   = {{(CP_W-BYTE_W){1'b0}}, in_byte_reg};
                end
                [8'hC0:8'hDF]:
                begin
                    part_next = {{(CP_W-BYTE_W){1'b0}}, in_byte_reg & LEAD2_MASK};
                    pend_next = PEND_ONE;
                end
                [8'hE0:8'hEF]:
                begin
                    part_next = {{(CP_W-BYTE_W){1'b0}}, in_byte_reg & LEAD3_MASK};
                    pend_next = PEND_TWO;
                end
                [8'hF0:8'hF7]:
                begin
                    part_next = {{(CP_W-BYTE_W){1'b0}}, in_byte_reg & LEAD4_MASK};
                    pend_next = PEND_THR;
                end
                default:
                begin
                    // stray continuation or invalid byte: skipped
                end
            endcase
        end
        if (in_last_reg)
        begin
            pend_next = PEND_IDLE;
            part_next = '0;
        end
        out_next.code_point     = done ? cp : '0;
        out_next.has_code_point = done;
        out_next.end_of_string  = in_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pend_reg    <= PEND_IDLE;
            part_reg    <= '0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (out_free)
                out_vld_reg <= fire && (done || in_last_reg);
            if (fire)
            begin
                pend_reg <= pend_next;
                part_reg <= part_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (fire)
            out_reg <= out_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OUT_DATA_W-CP_W){1'b0}}, out_reg.code_point};
    assign m_tuser  = out_reg.has_code_point;
    assign m_tlast  = out_reg.end_of_string;

    // a transaction without a code point carries zero
    a_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("code point not zero without has_code_point");

    // only the final byte may give a result with no code point
    a_has_or_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser || m_tlast))
        else $error("empty result that is not end of string");

    // the final byte leaves the decoder idle
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last_reg |=> pend_reg == PEND_IDLE && part_reg == '0)
        else $error("decoder not idle after final byte");

    // a completed multibyte sequence clears the partial value
    a_part_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pend_reg == PEND_ONE |=> part_reg == '0 && pend_reg == PEND_IDLE)
        else $error("partial value kept after sequence end");

endmodule

`default_nettype wire

### tb/utf8_stream_decoder_unit_checker.sv
// Scoreboard for utf8_stream_decoder_unit: decodes accepted bytes on its own
// and compares every result transaction in order. Depends on u8sd_pkg.
`timescale 1ns / 1ps

module utf8_stream_decoder_unit_checker
    import u8sd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    output int                    mismatch_count,
    output int                    results_owed,
    output int                    results_seen,
    output int                    code_points_seen
);

    logic [PEND_W-1:0] cont_left;
    logic [CP_W-1:0]   cp_acc;
    u8sd_result_t      owed_results[$];

    initial
    begin
        mismatch_count   = 0;
        results_owed     = 0;
        results_seen     = 0;
        code_points_seen = 0;
        cont_left        = PEND_IDLE;
        cp_acc           = '0;
    end

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic eos);
        u8sd_result_t    res;
        logic            done;
        logic [CP_W-1:0] cp;
        done = 1'b0;
        cp   = '0;
        if (cont_left != PEND_IDLE)
        begin
            cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
            cont_left = cont_left - PEND_ONE;
            if (cont_left == PEND_IDLE)
            begin
                done   = 1'b1;
                cp     = cp_acc;
                cp_acc = '0;
            end
        end
        else
        begin
            casez (b)
                8'b0???????:
                begin
                    done = 1'b1;
                    cp   = CP_W'(b);
                end
                8'b110?????:
                begin
                    cp_acc    = CP_W'(b & LEAD2_MASK);
                    cont_left = PEND_ONE;
                end
                8'b1110????:
                begin
                    cp_acc    = CP_W'(b & LEAD3_MASK);
                    cont_left = PEND_TWO;
                end
                8'b11110???:
                begin
                    cp_acc    = CP_W'(b & LEAD4_MASK);
                    cont_left = PEND_THR;
                end
                default:
                begin
                    // stray continuation or invalid byte, dropped
                end
            endcase
        end
        if (eos)
        begin
            cont_left = PEND_IDLE;
            cp_acc    = '0;
        end
        if (eos || done)
        begin
            res.code_point     = done ? cp : '0;
            res.has_code_point = done;
            res.end_of_string  = eos;
            owed_results = {owed_results, res};
        end
    endtask

    task automatic flag_mismatch(input string what, input u8sd_result_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s: expected cp=%06h has=%0b eos=%0b, got tdata=%06h %s",
                     $time, what, want.code_point, want.has_code_point,
                     want.end_of_string, m_tdata,
                     $sformatf("tuser=%0b tlast=%0b", m_tuser, m_tlast));
    endtask

    task automatic check_result();
        u8sd_result_t            want;
        logic [OUT_DATA_W-1:0]   want_data;
        results_seen++;
        if (m_tuser)
            code_points_seen++;
        if (owed_results.size() == 0)
        begin
            want = '0;
            flag_mismatch("unexpected result", want);
        end
        else
        begin
            want      = owed_results.pop_front();
            want_data = {{(OUT_DATA_W - CP_W){1'b0}}, want.code_point};
            if (m_tdata !== want_data || m_tuser !== want.has_code_point ||
                m_tlast !== want.end_of_string)
                flag_mismatch("result mismatch", want);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_left = PEND_IDLE;
            cp_acc    = '0;
            owed_results.delete();
            results_owed = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            results_owed = owed_results.size();
        end
    end

endmodule

### tb/utf8_stream_decoder_unit_tb.sv
// Testbench top for utf8_stream_decoder_unit: clock, reset, byte-string stimulus
// and verdict. Depends on u8sd_pkg and utf8_stream_decoder_unit_checker.
`timescale 1ns / 1ps

module utf8_stream_decoder_unit_tb;
    import u8sd_pkg::*;

    localparam int  RANDOM_BYTES = 1850;
    localparam time LIMIT_NS     = 400_000;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    int mismatch_count;
    int results_owed;
    int results_seen;
    int code_points_seen;
    int bytes_sent;
    int strings_sent;
    bit steady;

    utf8_stream_decoder_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    utf8_stream_decoder_unit_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .mismatch_count   (mismatch_count),
        .results_owed     (results_owed),
        .results_seen     (results_seen),
        .code_points_seen (code_points_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout with %0d results still owed", results_owed);
        $display("end of test: mismatches");
        $finish;
    end

    // sink backpressure
    always @(negedge clk)
        m_tready <= steady || ($urandom_range(99) >= 33);

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eos);
        while (!steady && $urandom_range(99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_string(input byte_q_t str);
        foreach (str[i])
            push_byte(str[i], i == str.size() - 1);
        strings_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] lead_byte(input int len);
        logic [BYTE_W-1:0] r;
        r = BYTE_W'($urandom);
        case (len)
            1:       return {1'b0, r[6:0]};
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] cont_byte(input bit clean);
        logic [BYTE_W-1:0] r;
        r = BYTE_W'($urandom);
        return clean ? {2'b10, r[5:0]} : r;
    endfunction

    task automatic make_random_string(output byte_q_t str);
        int kind;
        int len;
        int n_cont;
        str = {};
        repeat ($urandom_range(1, 8))
        begin
            kind   = $urandom_range(99);
            len    = $urandom_range(1, 4);
            n_cont = len - 1;
            if (kind < 72)
            begin
                str = {str, lead_byte(len)};
                repeat (n_cont)
                    str = {str, cont_byte(kind < 60)};
            end
            else if (kind < 82)
                str = {str, ($urandom_range(1) ? BYTE_W'($urandom_range(8'h80, 8'hBF))
                                               : BYTE_W'($urandom_range(8'hF8, 8'hFF)))};
            else if (kind < 92)
            begin
                len = $urandom_range(2, 4);
                str = {str, lead_byte(len)};
                repeat ($urandom_range(0, len - 2))
                    str = {str, cont_byte(1'b1)};
            end
            else
                str = {str, BYTE_W'($urandom)};
        end
        // some strings stop in the middle of a sequence
        if ($urandom_range(9) == 0)
        begin
            len = $urandom_range(2, 4);
            str = {str, lead_byte(len)};
            repeat ($urandom_range(0, len - 2))
                str = {str, cont_byte(1'b1)};
        end
    endtask

    initial
    begin
        byte_q_t str;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        steady       = 1'b0;
        bytes_sent   = 0;
        strings_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_string('{8'h00});
        send_string('{8'h7F, 8'h41, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                      8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF});
        send_string('{8'h80, 8'hFF, 8'hF8, 8'hC3, 8'h41});
        send_string('{8'hE2, 8'h82});
        send_string('{8'hBF});
        send_string('{8'hC0});

        while (bytes_sent < RANDOM_BYTES + 25)
        begin
            steady = (strings_sent >= 60 && strings_sent < 100);
            make_random_string(str);
            send_string(str);
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        wait (results_owed == 0);
        repeat (8) @(posedge clk);

        $display("sent %0d bytes in %0d strings", bytes_sent, strings_sent);
        $display("checked %0d results, %0d with a code point", results_seen, code_points_seen);
        if (mismatch_count == 0 && results_owed == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### utf8_stream_decoder_unit.f
hw/rtl/u8sd_pkg.sv
hw/rtl/utf8_stream_decoder_unit.sv
tb/utf8_stream_decoder_unit_checker.sv
tb/utf8_stream_decoder_unit_tb.sv
